[rtl/shadow_crop_matrix_unit_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the shadow crop matrix unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef SHADOW_CROP_MATRIX_UNIT_MACROS_SVH
`define SHADOW_CROP_MATRIX_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SCMU_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCMU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define SCMU_ASSERT(label, clk, rst_n, prop, msg)
`define SCMU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[rtl/scmu_pkg.sv]
// ---------------------------------------------------------------------------
// Shadow crop matrix package
// Widths, reset values, queue item and divider result types and saturation helper.
// ---------------------------------------------------------------------------
package scmu_pkg;
	localparam int CLIP_W = 52;
	localparam logic [63:0] MROW0_RST = 64'd4096;
	localparam logic [63:0] MROW1_RST = 64'd4096 << 16;
	localparam logic [63:0] MROW2_RST = 64'd4096 << 32;
	localparam logic [63:0] MROW3_RST = 64'd4096 << 48;
	localparam logic signed [31:0] I32_MAX = 32'sh7FFFFFFF;
	localparam logic signed [31:0] I32_MIN = 32'sh80000000;
	localparam logic signed [32:0] ONE_Q16 = 33'sd65536;
	localparam logic signed [CLIP_W-1:0] TWO_Q16 = CLIP_W'(131072);

	typedef struct packed {
		logic signed [CLIP_W-1:0] cx;
		logic signed [CLIP_W-1:0] cy;
		logic signed [CLIP_W-1:0] cz;
		logic signed [CLIP_W-1:0] cw;
		logic last;
	} clip_item_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic zero;
		logic signed [31:0] quo;
	} div_res_t;

	function automatic logic signed [31:0] sat32(input logic neg, input logic [63:0] m);
		logic signed [31:0] r;
		if (neg) begin
			if (m >= 64'h8000_0000) r = I32_MIN;
			else r = $signed(32'd0 - m[31:0]);
		end else begin
			if (m > 64'h7FFF_FFFF) r = I32_MAX;
			else r = $signed(m[31:0]);
		end
		return r;
	endfunction
endpackage

[rtl/scmu_point_if.sv]
// ---------------------------------------------------------------------------
// Corner point channel
// Carries one bounding box corner per request.
// ---------------------------------------------------------------------------
interface scmu_point_if;
	logic valid;
	logic ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic last_point;
	modport source(output valid, point_x, point_y, point_z, last_point, input ready);
	modport sink(input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

[rtl/scmu_crop_if.sv]
// ---------------------------------------------------------------------------
// Crop result channel
// Carries the crop scale, offset and status of one box per request.
// ---------------------------------------------------------------------------
interface scmu_crop_if;
	logic valid;
	logic ready;
	logic signed [31:0] scale_x;
	logic signed [31:0] scale_y;
	logic signed [31:0] scale_z;
	logic signed [31:0] shift_x;
	logic signed [31:0] shift_y;
	logic signed [31:0] shift_z;
	logic status;
	modport source(output valid, scale_x, scale_y, scale_z, shift_x, shift_y, shift_z,
		status, input ready);
	modport sink(input valid, scale_x, scale_y, scale_z, shift_x, shift_y, shift_z,
		status, output ready);
endinterface

[rtl/scmu_div.sv]
// ---------------------------------------------------------------------------
// Iterative Q16 divider
// Restoring division of (num * 2^16) by den, one quotient bit per cycle,
// truncated toward zero and saturated to 32 bits.
// ---------------------------------------------------------------------------
module scmu_div import scmu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [CLIP_W-1:0] num,
	input  logic signed [CLIP_W-1:0] den,
	output div_res_t res
);
	logic busy_q, done_q, zero_q, neg_q;
	logic [5:0] cnt_q;
	logic [CLIP_W-1:0] rem_q, dmag_q;
	logic [32:0] nlow_q;
	logic [32:0] quo_bits_q;
	logic signed [31:0] quo_q;
	logic [CLIP_W-1:0] nmag, dmag;
	logic ovf;
	logic [CLIP_W:0] trial;
	logic bit_n;

	assign nmag = num[CLIP_W-1] ? CLIP_W'(0) - num : num;
	assign dmag = den[CLIP_W-1] ? CLIP_W'(0) - den : den;
	assign ovf = (70'(nmag) >= (70'(dmag) << 17));
	assign trial = {rem_q, nlow_q[32]};
	assign bit_n = (trial >= (CLIP_W+1)'(dmag_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0 || ovf) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q && cnt_q == 6'd1) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[CLIP_W-1] != den[CLIP_W-1];
			dmag_q <= dmag;
			rem_q <= nmag >> 17;
			nlow_q <= {nmag[16:0], 16'd0};
			cnt_q <= 6'd33;
			quo_bits_q <= '0;
			zero_q <= (den == '0);
			if (den == '0) begin
				if (num == '0) quo_q <= '0;
				else if (num[CLIP_W-1]) quo_q <= I32_MIN;
				else quo_q <= I32_MAX;
			end else if (ovf) begin
				quo_q <= sat32(num[CLIP_W-1] != den[CLIP_W-1], 64'hFFFF_FFFF);
			end
		end else if (busy_q) begin
			rem_q <= bit_n ? CLIP_W'(trial - (CLIP_W+1)'(dmag_q)) : trial[CLIP_W-1:0];
			nlow_q <= {nlow_q[31:0], 1'b0};
			quo_bits_q <= {quo_bits_q[31:0], bit_n};
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) quo_q <= sat32(neg_q, 64'({quo_bits_q[31:0], bit_n}));
		end
	end

	assign res.busy = busy_q;
	assign res.done = done_q;
	assign res.zero = zero_q;
	assign res.quo = quo_q;
endmodule

[rtl/scmu_queue.sv]
// ---------------------------------------------------------------------------
// Clip coordinate queue
// Two-entry queue that decouples the transform from the divide sequencer.
// ---------------------------------------------------------------------------
module scmu_queue import scmu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  clip_item_t push_item,
	output logic pop_valid,
	input  logic pop,
	output clip_item_t pop_item
);
	clip_item_t mem_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] count_q;
	logic do_push, do_pop;

	assign push_ready = count_q != 2'd2;
	assign pop_valid = count_q != 2'd0;
	assign do_push = push_valid && push_ready;
	assign do_pop = pop && pop_valid;
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) wptr_q <= !wptr_q;
			if (do_pop) rptr_q <= !rptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wptr_q] <= push_item;
	end
endmodule

[rtl/scmu_front.sv]
// ---------------------------------------------------------------------------
// Transform front end
// Holds the matrix rows and forms the four clip coordinates of a corner
// with one shared multiplier, one product per cycle.
// ---------------------------------------------------------------------------
module scmu_front import scmu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [7:0] cfg_index,
	input  logic [63:0] cfg_data,
	scmu_point_if.sink point,
	output logic push_valid,
	input  logic push_ready,
	output clip_item_t push_item
);
	logic [63:0] mrow_q [4];
	logic busy_q, push_q, pv_s1;
	logic [4:0] cnt_q;
	logic [3:0] pidx_s1;
	logic signed [32:0] p_q [3];
	logic last_q;
	logic signed [48:0] prod_s1;
	logic signed [CLIP_W-1:0] acc_q;
	logic signed [CLIP_W-1:0] clip_q [4];
	logic signed [15:0] coef;
	logic signed [32:0] pmux;
	logic signed [CLIP_W-1:0] sum;
	logic issue;

	assign point.ready = !busy_q;
	assign issue = busy_q && !cnt_q[4];
	assign coef = $signed(mrow_q[cnt_q[3:2]][16*cnt_q[1:0] +: 16]);
	assign pmux = (cnt_q[1:0] == 2'd3) ? ONE_Q16 : p_q[cnt_q[1:0]];
	assign sum = ((pidx_s1[1:0] == 2'd0) ? CLIP_W'(0) : acc_q) + CLIP_W'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mrow_q[0] <= MROW0_RST;
			mrow_q[1] <= MROW1_RST;
			mrow_q[2] <= MROW2_RST;
			mrow_q[3] <= MROW3_RST;
			busy_q <= 1'b0;
			push_q <= 1'b0;
			pv_s1 <= 1'b0;
			cnt_q <= 5'd0;
		end else begin
			if (cfg_we && cfg_index < 8'd4) mrow_q[cfg_index[1:0]] <= cfg_data;
			pv_s1 <= issue;
			if (point.valid && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q <= 5'd0;
			end else if (issue) begin
				cnt_q <= cnt_q + 5'd1;
			end
			if (pv_s1 && pidx_s1 == 4'd15) push_q <= 1'b1;
			if (push_q && push_ready) begin
				push_q <= 1'b0;
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (point.valid && !busy_q) begin
			p_q[0] <= 33'(point.point_x);
			p_q[1] <= 33'(point.point_y);
			p_q[2] <= 33'(point.point_z);
			last_q <= point.last_point;
		end
		if (issue) begin
			prod_s1 <= coef * pmux;
			pidx_s1 <= cnt_q[3:0];
		end
		if (pv_s1) begin
			if (pidx_s1[1:0] == 2'd3) clip_q[pidx_s1[3:2]] <= sum;
			else acc_q <= sum;
		end
	end

	assign push_valid = push_q;
	assign push_item.cx = clip_q[0];
	assign push_item.cy = clip_q[1];
	assign push_item.cz = clip_q[2];
	assign push_item.cw = clip_q[3];
	assign push_item.last = last_q;
endmodule

[rtl/scmu_back.sv]
// ---------------------------------------------------------------------------
// Divide sequencer back end
// Performs the perspective divides, keeps the box extents and, on the last
// corner, forms the crop scales and offsets into the output register.
// ---------------------------------------------------------------------------
`include "shadow_crop_matrix_unit_macros.svh"
module scmu_back import scmu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic pop_valid,
	output logic pop,
	input  clip_item_t pop_item,
	scmu_crop_if.source crop
);
	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_DIV_GO = 3'd1;
	localparam logic [2:0] B_DIV_WAIT = 3'd2;
	localparam logic [2:0] B_SC_GO = 3'd3;
	localparam logic [2:0] B_SC_WAIT = 3'd4;
	localparam logic [2:0] B_MUL = 3'd5;
	localparam logic [2:0] B_SAT = 3'd6;
	localparam logic [2:0] B_EMIT = 3'd7;

	logic [2:0] state_q;
	logic [1:0] axis_q;
	clip_item_t item_q;
	logic signed [31:0] low_x_q, high_x_q, low_y_q, high_y_q, high_z_q;
	logic degen_q, szero_q, out_v_q;
	logic signed [31:0] sc_q [3];
	logic signed [31:0] of_q [3];
	logic [64:0] prod_s1;
	logic pneg_s1;
	logic div_start;
	logic signed [CLIP_W-1:0] div_num, div_den;
	div_res_t dres;
	logic signed [31:0] hi_sel, lo_sel, sc_sel;
	logic signed [32:0] diff, bsum;
	logic [32:0] bsum_mag;
	logic [31:0] sc_mag;
	logic [47:0] ofs_m;
	logic emit;

	scmu_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .res(dres)
	);

	always_comb begin
		case (axis_q)
			2'd0: begin
				hi_sel = high_x_q;
				lo_sel = low_x_q;
			end
			2'd1: begin
				hi_sel = high_y_q;
				lo_sel = low_y_q;
			end
			default: begin
				hi_sel = high_z_q;
				lo_sel = -32'sd65536;
			end
		endcase
	end

	assign sc_sel = sc_q[axis_q];
	assign diff = 33'(hi_sel) - 33'(lo_sel);
	assign bsum = 33'(hi_sel) + 33'(lo_sel);
	assign bsum_mag = bsum[32] ? 33'd0 - bsum : bsum;
	assign sc_mag = sc_sel[31] ? 32'd0 - sc_sel : sc_sel;
	assign ofs_m = prod_s1[64:17];

	assign pop = (state_q == B_IDLE) && pop_valid;
	assign div_start = (state_q == B_DIV_GO) || (state_q == B_SC_GO);
	assign div_num = (state_q == B_SC_GO) ? TWO_Q16 :
		(axis_q == 2'd0) ? item_q.cx : (axis_q == 2'd1) ? item_q.cy : item_q.cz;
	assign div_den = (state_q == B_SC_GO) ? CLIP_W'(diff) : item_q.cw;
	assign emit = (state_q == B_EMIT) && (!out_v_q || crop.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			axis_q <= 2'd0;
			out_v_q <= 1'b0;
			low_x_q <= I32_MAX;
			low_y_q <= I32_MAX;
			high_x_q <= I32_MIN;
			high_y_q <= I32_MIN;
			high_z_q <= I32_MIN;
			degen_q <= 1'b0;
			szero_q <= 1'b0;
		end else begin
			if (crop.ready) out_v_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					axis_q <= 2'd0;
					if (pop_valid) state_q <= B_DIV_GO;
				end
				B_DIV_GO: state_q <= B_DIV_WAIT;
				B_DIV_WAIT: begin
					if (dres.done) begin
						if (dres.zero) degen_q <= 1'b1;
						case (axis_q)
							2'd0: begin
								if (dres.quo < low_x_q) low_x_q <= dres.quo;
								if (dres.quo > high_x_q) high_x_q <= dres.quo;
							end
							2'd1: begin
								if (dres.quo < low_y_q) low_y_q <= dres.quo;
								if (dres.quo > high_y_q) high_y_q <= dres.quo;
							end
							default: begin
								if (dres.quo > high_z_q) high_z_q <= dres.quo;
							end
						endcase
						if (axis_q == 2'd2) begin
							axis_q <= 2'd0;
							szero_q <= 1'b0;
							state_q <= item_q.last ? B_SC_GO : B_IDLE;
						end else begin
							axis_q <= axis_q + 2'd1;
							state_q <= B_DIV_GO;
						end
					end
				end
				B_SC_GO: state_q <= B_SC_WAIT;
				B_SC_WAIT: begin
					if (dres.done) begin
						if (dres.zero) szero_q <= 1'b1;
						state_q <= B_MUL;
					end
				end
				B_MUL: state_q <= B_SAT;
				B_SAT: begin
					if (axis_q == 2'd2) begin
						state_q <= B_EMIT;
					end else begin
						axis_q <= axis_q + 2'd1;
						state_q <= B_SC_GO;
					end
				end
				B_EMIT: begin
					if (emit) begin
						out_v_q <= 1'b1;
						low_x_q <= I32_MAX;
						low_y_q <= I32_MAX;
						high_x_q <= I32_MIN;
						high_y_q <= I32_MIN;
						high_z_q <= I32_MIN;
						degen_q <= 1'b0;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) item_q <= pop_item;
		if (state_q == B_SC_WAIT && dres.done) sc_q[axis_q] <= dres.quo;
		if (state_q == B_MUL) begin
			prod_s1 <= 65'(bsum_mag) * 65'(sc_mag);
			pneg_s1 <= bsum[32] != sc_sel[31];
		end
		if (state_q == B_SAT) of_q[axis_q] <= sat32(!pneg_s1 && ofs_m != '0, 64'(ofs_m));
		if (emit) begin
			crop.scale_x <= sc_q[0];
			crop.scale_y <= sc_q[1];
			crop.scale_z <= sc_q[2];
			crop.shift_x <= of_q[0];
			crop.shift_y <= of_q[1];
			crop.shift_z <= of_q[2];
			crop.status <= szero_q || degen_q;
		end
	end

	assign crop.valid = out_v_q;

	`SCMU_ASSERT(a_start_idle, clk, arst_n, div_start |-> !dres.busy, "divider restarted busy")
	`SCMU_ASSERT(a_emit_clear, clk, arst_n, emit |=> (low_x_q == I32_MAX && !degen_q),
		"box not cleared after emit")
	`SCMU_ASSERT(a_emit_hold, clk, arst_n,
		(state_q == B_EMIT && out_v_q && !crop.ready) |=> (state_q == B_EMIT),
		"result overwritten while output full")
endmodule

[rtl/shadow_crop_matrix_unit.sv]
// ---------------------------------------------------------------------------
// Shadow crop matrix unit
// Crop scale and offset of one bounding box for a cascaded shadow map.
// ---------------------------------------------------------------------------
// Each corner request is transformed by the configured Q4.12 matrix, one
// product per cycle on a single multiplier, and is queued. The back end then
// performs three perspective divides on one shared divider that yields one
// quotient bit per cycle, and the last corner of a box adds three scale
// divides and offsets. The divider sets the rate. The result waits in an
// output register while the next box proceeds.
module shadow_crop_matrix_unit import scmu_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [7:0] cfg_index,
	input  logic [63:0] cfg_data,
	scmu_point_if.sink point,
	scmu_crop_if.source crop
);
	logic push_valid, push_ready, pop_valid, pop;
	clip_item_t push_item, pop_item;

	scmu_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .point(point), .push_valid(push_valid),
		.push_ready(push_ready), .push_item(push_item)
	);

	scmu_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push_valid(push_valid), .push_ready(push_ready),
		.push_item(push_item), .pop_valid(pop_valid), .pop(pop), .pop_item(pop_item)
	);

	scmu_back u_back (
		.clk(clk), .arst_n(arst_n), .pop_valid(pop_valid), .pop(pop),
		.pop_item(pop_item), .crop(crop)
	);
endmodule

[tb/sv/tb.sv]
// ---------------------------------------------------------------------------
// Shadow crop matrix unit testbench
// Sends bounding box corners under random gaps and stalls, predicts the crop
// scale, offset and status of each box and checks every result in order.
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import scmu_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 300;
	localparam int RANDOM_ITEMS = 1230;
	localparam int REG_ROW0 = 0;
	localparam int REG_ROW1 = 1;
	localparam int REG_ROW2 = 2;
	localparam int REG_ROW3 = 3;
	localparam int REG_COUNT = 4;
	localparam int Q16_ONE = 65536;

	typedef struct {
		int scale_x;
		int scale_y;
		int scale_z;
		int shift_x;
		int shift_y;
		int shift_z;
		bit status;
	} crop_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_index;
	logic [63:0] cfg_data;

	scmu_point_if point_ch();
	scmu_crop_if crop_ch();

	shadow_crop_matrix_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.point(point_ch),
		.crop(crop_ch)
	);

	logic [63:0] matrix_rows [REG_COUNT];
	int box_low_x, box_high_x, box_low_y, box_high_y, box_high_z;
	bit box_degenerate;
	crop_t expected_crops[$];
	int errors;
	int points_sent;
	int crops_checked;
	int idle_cycles;
	bit quiet;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic int clamp32(bit neg, longint unsigned m);
		if (neg) begin
			if (m >= 64'h8000_0000) return int'(I32_MIN);
			return int'(-longint'(m));
		end
		if (m > 64'h7FFF_FFFF) return int'(I32_MAX);
		return int'(m);
	endfunction

	function automatic int q16_divide(longint num, longint den, inout bit zero);
		bit neg;
		longint unsigned n, d, q, r;
		neg = (num < 0) != (den < 0);
		n = abs64(num);
		d = abs64(den);
		if (d == 0) begin
			zero = 1'b1;
			if (num > 0) return int'(I32_MAX);
			if (num < 0) return int'(I32_MIN);
			return 0;
		end
		q = n / d;
		r = n % d;
		if (q > 32768) return clamp32(neg, 64'hFFFF_FFFF);
		q = q << 16;
		for (int i = 15; i >= 0; i--) begin
			r = r << 1;
			if (r >= d) begin
				r = r - d;
				q = q | (64'd1 << i);
			end
		end
		return clamp32(neg, q);
	endfunction

	function automatic int crop_offset(longint sum, int scale);
		longint unsigned m;
		bit prod_neg;
		m = (abs64(sum) * abs64(longint'(scale))) >> 17;
		prod_neg = (sum < 0) != (scale < 0);
		return clamp32(!prod_neg && m != 0, m);
	endfunction

	function automatic void clear_box();
		box_low_x = int'(I32_MAX);
		box_low_y = int'(I32_MAX);
		box_high_x = int'(I32_MIN);
		box_high_y = int'(I32_MIN);
		box_high_z = int'(I32_MIN);
		box_degenerate = 1'b0;
	endfunction

	function automatic void predict_corner(int px, int py, int pz, bit last);
		longint p [4];
		longint clip [4];
		longint lo [3];
		longint hi [3];
		int sc [3];
		int of [3];
		int nx, ny, nz;
		bit zero;
		crop_t c;
		p[0] = px;
		p[1] = py;
		p[2] = pz;
		p[3] = Q16_ONE;
		for (int r = 0; r < 4; r++) begin
			clip[r] = 0;
			for (int k = 0; k < 4; k++)
				clip[r] += longint'($signed(matrix_rows[r][16*k +: 16])) * p[k];
		end
		zero = 1'b0;
		nx = q16_divide(clip[0], clip[3], zero);
		ny = q16_divide(clip[1], clip[3], zero);
		nz = q16_divide(clip[2], clip[3], zero);
		if (zero) box_degenerate = 1'b1;
		if (nx < box_low_x) box_low_x = nx;
		if (nx > box_high_x) box_high_x = nx;
		if (ny < box_low_y) box_low_y = ny;
		if (ny > box_high_y) box_high_y = ny;
		if (nz > box_high_z) box_high_z = nz;
		if (!last) return;
		lo[0] = box_low_x;
		hi[0] = box_high_x;
		lo[1] = box_low_y;
		hi[1] = box_high_y;
		lo[2] = -Q16_ONE;
		hi[2] = box_high_z;
		zero = 1'b0;
		for (int k = 0; k < 3; k++) begin
			sc[k] = q16_divide(2 * Q16_ONE, hi[k] - lo[k], zero);
			of[k] = crop_offset(hi[k] + lo[k], sc[k]);
		end
		c.scale_x = sc[0];
		c.scale_y = sc[1];
		c.scale_z = sc[2];
		c.shift_x = of[0];
		c.shift_y = of[1];
		c.shift_z = of[2];
		c.status = zero || box_degenerate;
		expected_crops.push_back(c);
		clear_box();
	endfunction

	function automatic int gap_len();
		int r;
		if (quiet) return 0;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		errors++;
		$display("mismatch on %s: got %0d (%08h), expected %0d (%08h)",
			field, got, got, want, want);
	endtask

	task automatic compare_field(string field, int got, int want);
		if (got !== want) report_mismatch(field, got, want);
	endtask

	// Input side: every accepted corner updates the predicted box.
	always @(posedge clk) begin
		if (arst_n && point_ch.valid && point_ch.ready) begin
			predict_corner(point_ch.point_x, point_ch.point_y, point_ch.point_z,
				point_ch.last_point);
			points_sent++;
		end
	end

	// Output side: random back pressure and in-order checking.
	int stall_left;
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				crop_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				crop_ch.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 99) < 20) stall_left = gap_len();
			end
		end
	end

	always @(posedge clk) begin
		crop_t want;
		if (arst_n && crop_ch.valid && crop_ch.ready) begin
			if (expected_crops.size() == 0) begin
				errors++;
				$display("crop request arrived with no box pending");
			end else begin
				want = expected_crops.pop_front();
				compare_field("scale_x", crop_ch.scale_x, want.scale_x);
				compare_field("scale_y", crop_ch.scale_y, want.scale_y);
				compare_field("scale_z", crop_ch.scale_z, want.scale_z);
				compare_field("shift_x", crop_ch.shift_x, want.shift_x);
				compare_field("shift_y", crop_ch.shift_y, want.shift_y);
				compare_field("shift_z", crop_ch.shift_z, want.shift_z);
				compare_field("status", crop_ch.status, want.status);
			end
			crops_checked++;
		end
	end

	always @(posedge clk) begin
		if ((point_ch.valid && point_ch.ready) || (crop_ch.valid && crop_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic send_corner(int px, int py, int pz, bit last);
		int gap;
		gap = gap_len();
		if (gap > 0) begin
			point_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		point_ch.valid <= 1'b1;
		point_ch.point_x <= px;
		point_ch.point_y <= py;
		point_ch.point_z <= pz;
		point_ch.last_point <= last;
		do @(posedge clk); while (!point_ch.ready);
	endtask

	task automatic wait_idle();
		@(posedge clk);
		point_ch.valid <= 1'b0;
		while (expected_crops.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(int idx, logic [63:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx[7:0];
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < REG_COUNT) matrix_rows[idx] = data;
		@(posedge clk);
	endtask

	task automatic load_matrix(logic [63:0] r0, logic [63:0] r1, logic [63:0] r2,
		logic [63:0] r3);
		wait_idle();
		write_reg(REG_ROW0, r0);
		write_reg(REG_ROW1, r1);
		write_reg(REG_ROW2, r2);
		write_reg(REG_ROW3, r3);
	endtask

	task automatic test_identity_extremes();
		send_corner(0, 0, 0, 1'b0);
		send_corner(int'(I32_MAX), int'(I32_MAX), int'(I32_MAX), 1'b0);
		send_corner(int'(I32_MIN), int'(I32_MIN), int'(I32_MIN), 1'b1);
		send_corner(32'h0001_0000, -32'sh0001_0000, 32'h0000_8000, 1'b0);
		send_corner(-32'sh0002_0000, 32'h0001_0000, 0, 1'b1);
	endtask

	task automatic test_zero_extent();
		send_corner(32'h0001_0000, 32'h0002_0000, -32'sh0000_8000, 1'b1);
	endtask

	task automatic test_z_below_minus_one();
		send_corner(32'h0000_4000, -32'sh0000_4000, -32'sh0003_0000, 1'b0);
		send_corner(-32'sh0000_4000, 32'h0000_4000, -32'sh0002_0000, 1'b1);
	endtask

	task automatic test_zero_w();
		load_matrix(MROW0_RST, MROW1_RST, MROW2_RST, 64'd0);
		send_corner(32'h0000_1000, -32'sh0000_1000, 0, 1'b0);
		send_corner(-32'sh0000_1000, 32'h0000_1000, 32'h0000_1000, 1'b1);
		load_matrix(MROW0_RST, MROW1_RST, MROW2_RST, MROW3_RST);
	endtask

	task automatic test_ignored_index();
		wait_idle();
		write_reg(REG_COUNT, {$urandom, $urandom});
		write_reg(255, {$urandom, $urandom});
		send_corner(32'h0000_8000, 32'h0000_c000, 32'h0000_2000, 1'b0);
		send_corner(-32'sh0000_8000, -32'sh0000_4000, 32'h0000_6000, 1'b1);
	endtask

	task automatic test_extreme_matrix();
		load_matrix({4{16'h7FFF}}, {4{16'h8000}}, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000},
			{16'h7FFF, 16'h0000, 16'h0000, 16'h0000});
		send_corner(int'(I32_MAX), int'(I32_MIN), 32'h0001_0000, 1'b0);
		send_corner(32'h0000_0001, -32'sh0000_0001, int'(I32_MAX), 1'b1);
		// The sender holds off here until every pending box has been returned.
		load_matrix({4{16'h8000}}, {4{16'h7FFF}}, {4{16'hFFFF}}, {4{16'h8000}});
		send_corner(int'(I32_MIN), int'(I32_MIN), int'(I32_MIN), 1'b1);
	endtask

	function automatic logic [15:0] small_entry();
		return 16'($signed($urandom_range(0, 8192)) - 4096);
	endfunction

	function automatic logic [63:0] small_row();
		return {small_entry(), small_entry(), small_entry(), small_entry()};
	endfunction

	task automatic test_random();
		int sent;
		int corners;
		int mode;
		int span;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			mode = $urandom_range(0, 9);
			if (mode < 7)
				load_matrix(small_row(), small_row(), small_row(),
					{16'($urandom_range(2048, 12288)), small_entry() >>> 3,
						small_entry() >>> 3, small_entry() >>> 3});
			else if (mode < 9)
				load_matrix({$urandom, $urandom}, {$urandom, $urandom},
					{$urandom, $urandom}, {$urandom, $urandom});
			else
				load_matrix(MROW0_RST, MROW1_RST, MROW2_RST, MROW3_RST);
			quiet = $urandom_range(0, 3) == 0;
			span = $urandom_range(0, 1) ? 32'h0004_0000 : 32'h0100_0000;
			repeat ($urandom_range(4, 10)) begin
				corners = $urandom_range(0, 9) == 0 ? $urandom_range(9, 16)
					: $urandom_range(1, 8);
				for (int k = 0; k < corners; k++) begin
					if ($urandom_range(0, 4) == 0)
						send_corner($urandom, $urandom, $urandom, k == corners - 1);
					else
						send_corner($signed($urandom_range(0, 2 * span)) - span,
							$signed($urandom_range(0, 2 * span)) - span,
							$signed($urandom_range(0, 2 * span)) - span,
							k == corners - 1);
					sent++;
				end
			end
			quiet = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		point_ch.valid = 1'b0;
		point_ch.point_x = '0;
		point_ch.point_y = '0;
		point_ch.point_z = '0;
		point_ch.last_point = 1'b0;
		crop_ch.ready = 1'b0;
		stall_left = 0;
		errors = 0;
		points_sent = 0;
		crops_checked = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		matrix_rows[0] = MROW0_RST;
		matrix_rows[1] = MROW1_RST;
		matrix_rows[2] = MROW2_RST;
		matrix_rows[3] = MROW3_RST;
		clear_box();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity_extremes();
		test_zero_extent();
		test_z_below_minus_one();
		test_zero_w();
		test_ignored_index();
		test_extreme_matrix();
		test_random();
		wait_idle();

		$display("%0d corners sent, %0d crop results checked, %0d mismatches",
			points_sent, crops_checked, errors);
		$display("covered extremes, zero w, zero extent, low z and random matrices");
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

[sim.f]
+incdir+rtl
rtl/scmu_pkg.sv
rtl/scmu_point_if.sv
rtl/scmu_crop_if.sv
rtl/scmu_div.sv
rtl/scmu_queue.sv
rtl/scmu_front.sv
rtl/scmu_back.sv
rtl/shadow_crop_matrix_unit.sv
tb/sv/tb.sv
